// File: sv/bc3ai_pkg.sv
// ----------------------------------------------------------------------------
// bc3ai_pkg
// Shared types and constants for the BC3 alpha index encoder pipeline.
// ----------------------------------------------------------------------------
package bc3ai_pkg;

  // Field widths
  localparam int ALPHA_W     = 8;
  localparam int IDX_W       = 3;
  localparam int PAL_ENTRIES = 8;
  localparam int BLOCK_PIXELS = 16;
  localparam int CNT_W       = 4;
  localparam int IDX_BITS_W  = IDX_W * BLOCK_PIXELS;
  localparam int ERR_W       = 20;
  localparam int SQ_W        = 2 * ALPHA_W;

  // Fixed palette levels of the four-level mode
  localparam logic [ALPHA_W-1:0] ALPHA_MIN = '0;
  localparam logic [ALPHA_W-1:0] ALPHA_MAX = 8'hFF;

  typedef logic [ALPHA_W-1:0] alpha_t;
  typedef logic [IDX_W-1:0]   idx_t;

  // Request as taken from the input channel
  typedef struct packed {
    alpha_t e0;
    alpha_t e1;
    alpha_t alpha;
  } in_req_t;

  // Request with its palette built
  typedef struct packed {
    alpha_t                        e0;
    alpha_t                        e1;
    alpha_t                        alpha;
    logic [PAL_ENTRIES-1:0][ALPHA_W-1:0] pal;
  } pal_req_t;

  // Request with its best palette index chosen
  typedef struct packed {
    alpha_t e0;
    alpha_t e1;
    idx_t   idx;
    alpha_t diff;
  } sel_req_t;

endpackage

// File: sv/bc3_alpha_index_encoder.sv
// ----------------------------------------------------------------------------
// bc3_alpha_index_encoder: BC3 alpha index encoder, one pixel alpha per request.
// Takes one request per cycle unless in_stall is high; one block result per 16 requests.
// Stages: input register, palette, nearest-entry select, accumulate/result.
// Synchronous active-low reset clears all valids and the block counters.
// ----------------------------------------------------------------------------
module bc3_alpha_index_encoder (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bc3ai_pkg::ALPHA_W-1:0]     in_endpoint_first,
  input  logic [bc3ai_pkg::ALPHA_W-1:0]     in_endpoint_second,
  input  logic [bc3ai_pkg::ALPHA_W-1:0]     in_pixel_alpha,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bc3ai_pkg::ALPHA_W-1:0]     out_first_endpoint_out,
  output logic [bc3ai_pkg::ALPHA_W-1:0]     out_second_endpoint_out,
  output logic [bc3ai_pkg::IDX_BITS_W-1:0]  out_index_bits,
  output logic [bc3ai_pkg::ERR_W-1:0]       out_alpha_error
);

  logic                 in_valid_r;
  bc3ai_pkg::in_req_t   in_req_r;
  logic                 in_load;
  logic                 pal_ready;
  logic                 pal_valid;
  bc3ai_pkg::pal_req_t  pal_req;
  logic                 sel_ready;
  logic                 sel_valid;
  bc3ai_pkg::sel_req_t  sel_req;
  logic                 acc_ready;

  // Input register
  assign in_stall = in_valid_r && !pal_ready;
  assign in_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_load) begin
      in_valid_r <= 1'b1;
    end else if (pal_ready) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_req_r.e0    <= in_endpoint_first;
      in_req_r.e1    <= in_endpoint_second;
      in_req_r.alpha <= in_pixel_alpha;
    end
  end

  // Palette build
  bc3ai_palette u_palette (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid_r),
    .up_req   (in_req_r),
    .up_ready (pal_ready),
    .dn_valid (pal_valid),
    .dn_req   (pal_req),
    .dn_ready (sel_ready)
  );

  // Nearest palette entry
  bc3ai_select u_select (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (pal_valid),
    .up_req   (pal_req),
    .up_ready (sel_ready),
    .dn_valid (sel_valid),
    .dn_req   (sel_req),
    .dn_ready (acc_ready)
  );

  // Block accumulation and result register
  bc3ai_accum u_accum (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .up_valid                (sel_valid),
    .up_req                  (sel_req),
    .up_ready                (acc_ready),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_first_endpoint_out  (out_first_endpoint_out),
    .out_second_endpoint_out (out_second_endpoint_out),
    .out_index_bits          (out_index_bits),
    .out_alpha_error         (out_alpha_error)
  );

endmodule

// File: sv/bc3ai_palette.sv
// ----------------------------------------------------------------------------
// bc3ai_palette
// Builds the eight-entry alpha palette from the two endpoints and registers it.
// ----------------------------------------------------------------------------
module bc3ai_palette (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  input  bc3ai_pkg::in_req_t  up_req,
  output logic                up_ready,
  output logic                dn_valid,
  output bc3ai_pkg::pal_req_t dn_req,
  input  logic                dn_ready
);

  // Floor division by 7 and 5 as reciprocal multiplies; exact for n <= 7*255 and n <= 5*255
  localparam int                NUM_W    = 11;
  localparam int                RECIP_SH = 16;
  localparam int                PROD_W   = NUM_W + RECIP_SH - 2;
  localparam logic [PROD_W-1:0] DIV7_MUL = PROD_W'(((1 << RECIP_SH) + 6) / 7);
  localparam logic [PROD_W-1:0] DIV5_MUL = PROD_W'(((1 << RECIP_SH) + 4) / 5);

  function automatic bc3ai_pkg::alpha_t div7(input logic [NUM_W-1:0] n);
    logic [PROD_W-1:0] p;
    p    = PROD_W'(n) * DIV7_MUL;
    div7 = p[RECIP_SH +: bc3ai_pkg::ALPHA_W];
  endfunction

  function automatic bc3ai_pkg::alpha_t div5(input logic [NUM_W-1:0] n);
    logic [PROD_W-1:0] p;
    p    = PROD_W'(n) * DIV5_MUL;
    div5 = p[RECIP_SH +: bc3ai_pkg::ALPHA_W];
  endfunction

  logic                 valid_r;
  bc3ai_pkg::pal_req_t  req_r;
  bc3ai_pkg::pal_req_t  req_nxt;
  logic                 load;

  assign up_ready = !valid_r || dn_ready;
  assign load     = up_valid && up_ready;
  assign dn_valid = valid_r;
  assign dn_req   = req_r;

  // Palette: endpoints, then six interpolated levels or four plus 0 and 255
  always_comb begin
    req_nxt.e0     = up_req.e0;
    req_nxt.e1     = up_req.e1;
    req_nxt.alpha  = up_req.alpha;
    req_nxt.pal    = '0;
    req_nxt.pal[0] = up_req.e0;
    req_nxt.pal[1] = up_req.e1;
    if (up_req.e0 > up_req.e1) begin
      for (int j = 0; j < 6; j++) begin
        req_nxt.pal[2 + j] = div7(NUM_W'(6 - j) * NUM_W'(up_req.e0)
                                + NUM_W'(j + 1) * NUM_W'(up_req.e1));
      end
    end else begin
      for (int j = 0; j < 4; j++) begin
        req_nxt.pal[2 + j] = div5(NUM_W'(4 - j) * NUM_W'(up_req.e0)
                                + NUM_W'(j + 1) * NUM_W'(up_req.e1));
      end
      req_nxt.pal[6] = bc3ai_pkg::ALPHA_MIN;
      req_nxt.pal[7] = bc3ai_pkg::ALPHA_MAX;
    end
  end

  // Stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (dn_ready) begin
      valid_r <= 1'b0;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (load) begin
      req_r <= req_nxt;
    end
  end

endmodule

// File: sv/bc3ai_select.sv
// ----------------------------------------------------------------------------
// bc3ai_select
// Picks the palette entry nearest the pixel alpha, lowest index on a tie.
// ----------------------------------------------------------------------------
module bc3ai_select (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  input  bc3ai_pkg::pal_req_t up_req,
  output logic                up_ready,
  output logic                dn_valid,
  output bc3ai_pkg::sel_req_t dn_req,
  input  logic                dn_ready
);

  logic                 valid_r;
  bc3ai_pkg::sel_req_t  req_r;
  bc3ai_pkg::sel_req_t  req_nxt;
  logic                 load;

  // Absolute differences and the compare tree levels
  bc3ai_pkg::alpha_t d_l0 [bc3ai_pkg::PAL_ENTRIES];
  bc3ai_pkg::alpha_t d_l1 [4];
  bc3ai_pkg::idx_t   i_l1 [4];
  bc3ai_pkg::alpha_t d_l2 [2];
  bc3ai_pkg::idx_t   i_l2 [2];

  assign up_ready = !valid_r || dn_ready;
  assign load     = up_valid && up_ready;
  assign dn_valid = valid_r;
  assign dn_req   = req_r;

  // Least |d| gives least d*d; left side wins ties so the lower index stays
  always_comb begin
    for (int i = 0; i < bc3ai_pkg::PAL_ENTRIES; i++) begin
      d_l0[i] = (up_req.alpha > up_req.pal[i]) ? (up_req.alpha - up_req.pal[i])
                                               : (up_req.pal[i] - up_req.alpha);
    end
    for (int i = 0; i < 4; i++) begin
      if (d_l0[2*i] <= d_l0[2*i + 1]) begin
        d_l1[i] = d_l0[2*i];
        i_l1[i] = bc3ai_pkg::IDX_W'(2*i);
      end else begin
        d_l1[i] = d_l0[2*i + 1];
        i_l1[i] = bc3ai_pkg::IDX_W'(2*i + 1);
      end
    end
    for (int i = 0; i < 2; i++) begin
      if (d_l1[2*i] <= d_l1[2*i + 1]) begin
        d_l2[i] = d_l1[2*i];
        i_l2[i] = i_l1[2*i];
      end else begin
        d_l2[i] = d_l1[2*i + 1];
        i_l2[i] = i_l1[2*i + 1];
      end
    end
    req_nxt.e0 = up_req.e0;
    req_nxt.e1 = up_req.e1;
    if (d_l2[0] <= d_l2[1]) begin
      req_nxt.diff = d_l2[0];
      req_nxt.idx  = i_l2[0];
    end else begin
      req_nxt.diff = d_l2[1];
      req_nxt.idx  = i_l2[1];
    end
  end

  // Stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (dn_ready) begin
      valid_r <= 1'b0;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (load) begin
      req_r <= req_nxt;
    end
  end

endmodule

// File: sv/bc3ai_accum.sv
// ----------------------------------------------------------------------------
// bc3ai_accum
// Packs indices and sums squared errors over a block; holds the block result.
// ----------------------------------------------------------------------------
module bc3ai_accum (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   up_valid,
  input  bc3ai_pkg::sel_req_t                    up_req,
  output logic                                   up_ready,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [bc3ai_pkg::ALPHA_W-1:0]          out_first_endpoint_out,
  output logic [bc3ai_pkg::ALPHA_W-1:0]          out_second_endpoint_out,
  output logic [bc3ai_pkg::IDX_BITS_W-1:0]       out_index_bits,
  output logic [bc3ai_pkg::ERR_W-1:0]            out_alpha_error
);

  localparam logic [bc3ai_pkg::CNT_W-1:0] CNT_LAST =
    bc3ai_pkg::CNT_W'(bc3ai_pkg::BLOCK_PIXELS - 1);

  logic [bc3ai_pkg::CNT_W-1:0]      cnt_r;
  logic [bc3ai_pkg::IDX_BITS_W-1:0] acc_r;
  logic [bc3ai_pkg::IDX_BITS_W-1:0] acc_nxt;
  logic [bc3ai_pkg::ERR_W-1:0]      sum_r;
  logic [bc3ai_pkg::ERR_W-1:0]      sum_nxt;
  logic [bc3ai_pkg::SQ_W-1:0]       sq;
  logic                             out_valid_r;
  bc3ai_pkg::alpha_t                e0_r;
  bc3ai_pkg::alpha_t                e1_r;
  logic [bc3ai_pkg::IDX_BITS_W-1:0] bits_r;
  logic [bc3ai_pkg::ERR_W-1:0]      err_r;
  logic                             take;
  logic                             last;
  logic                             out_take;

  // Only the closing pixel of a block waits on a full result register
  assign out_take  = out_valid_r && !out_stall;
  assign up_ready  = !((cnt_r == CNT_LAST) && out_valid_r && out_stall);
  assign take      = up_valid && up_ready;
  assign last      = take && (cnt_r == CNT_LAST);

  assign out_valid               = out_valid_r;
  assign out_first_endpoint_out  = e0_r;
  assign out_second_endpoint_out = e1_r;
  assign out_index_bits          = bits_r;
  assign out_alpha_error         = err_r;

  // Square the winning distance, add it, drop the index into its slot
  always_comb begin
    sq      = bc3ai_pkg::SQ_W'(up_req.diff) * bc3ai_pkg::SQ_W'(up_req.diff);
    sum_nxt = sum_r + bc3ai_pkg::ERR_W'(sq);
    acc_nxt = acc_r;
    for (int s = 0; s < bc3ai_pkg::BLOCK_PIXELS; s++) begin
      if (cnt_r == bc3ai_pkg::CNT_W'(s)) begin
        acc_nxt[bc3ai_pkg::IDX_W*s +: bc3ai_pkg::IDX_W] =
          acc_r[bc3ai_pkg::IDX_W*s +: bc3ai_pkg::IDX_W] | up_req.idx;
      end
    end
  end

  // Block state; clears after the sixteenth pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      acc_r <= '0;
      sum_r <= '0;
    end else if (last) begin
      cnt_r <= '0;
      acc_r <= '0;
      sum_r <= '0;
    end else if (take) begin
      cnt_r <= cnt_r + 1'b1;
      acc_r <= acc_nxt;
      sum_r <= sum_nxt;
    end
  end

  // Result valid: a new block result wins over the take
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (last) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (last) begin
      e0_r   <= up_req.e0;
      e1_r   <= up_req.e1;
      bits_r <= acc_nxt;
      err_r  <= sum_nxt;
    end
  end

endmodule
